[rtl/assert_macros.svh]
// assertion macros used by the port checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every edge outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication checked in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/ltc_pkg.sv]
// types, constants and helpers of the tile tag cache
`default_nettype none
package ltc_pkg;
	localparam int CACHE_SLOTS = 16;
	localparam int SLOT_W = $clog2(CACHE_SLOTS);
	localparam int CNT_W = $clog2(CACHE_SLOTS + 1);
	localparam int GRP_SIZE = 4;
	localparam int NUM_GRPS = (CACHE_SLOTS + GRP_SIZE - 1) / GRP_SIZE;
	localparam logic [31:0] STAMP_MAX = 32'hFFFF_FFFF;
	localparam logic [4:0] CFG_RESET = 5'd16;

	typedef enum logic [1:0] {
		ST_MISS = 2'd0,
		ST_HIT = 2'd1,
		ST_INSERTED = 2'd2,
		ST_IGNORED = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OP_LOOKUP,
		OP_INSERT,
		OP_IGNORE
	} op_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_EVAL,
		BK_DONE
	} bk_state_t;

	typedef struct packed {
		op_t op;
		logic [15:0] layer_id;
		logic [4:0] zoom;
		logic [23:0] tile_x;
		logic [23:0] tile_y;
		logic [23:0] tile_length;
	} item_t;

	// candidate for replacement by oldest stamp
	typedef struct packed {
		logic found;
		logic [31:0] stamp;
		logic [SLOT_W-1:0] idx;
	} cand_t;

	// lower candidate wins ties
	function automatic cand_t cand_pick(input cand_t a, input cand_t b);
		cand_t r;
		r = a;
		if (b.found && (!a.found || b.stamp < a.stamp))
			r = b;
		return r;
	endfunction
endpackage
`default_nettype wire

[rtl/ltc_front.sv]
// front end: takes requests, classifies them and queues them
`default_nettype none
module ltc_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_ready,
	input wire logic kind,
	input wire logic [15:0] layer_id,
	input wire logic [4:0] zoom,
	input wire logic [23:0] tile_x,
	input wire logic [23:0] tile_y,
	input wire logic [23:0] tile_length,
	output logic item_valid,
	output ltc_pkg::item_t item,
	input wire logic item_pop
);
	import ltc_pkg::*;

	item_t fifo_q [2];
	logic rd_ptr_q, wr_ptr_q;
	logic [1:0] count_q;
	item_t new_item;
	logic push;

	always_comb begin
		new_item.layer_id = layer_id;
		new_item.zoom = zoom;
		new_item.tile_x = tile_x;
		new_item.tile_y = tile_y;
		new_item.tile_length = tile_length;
		if (!kind)
			new_item.op = OP_LOOKUP;
		else if (tile_length == 24'd0)
			new_item.op = OP_IGNORE;
		else
			new_item.op = OP_INSERT;
	end

	assign req_ready = (count_q != 2'd2);
	assign push = req_valid && req_ready;
	assign item_valid = (count_q != 2'd0);
	assign item = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= new_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (item_pop)
				rd_ptr_q <= ~rd_ptr_q;
			case ({push, item_pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule
`default_nettype wire

[rtl/ltc_back.sv]
// back end: tag store, compare, oldest search and write-back
`default_nettype none
module ltc_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [ltc_pkg::CNT_W-1:0] n_active,
	input wire logic item_valid,
	input wire ltc_pkg::item_t item,
	output logic item_pop,
	output logic rsp_valid,
	input wire logic rsp_ready,
	output logic [1:0] status,
	output logic [3:0] slot,
	output logic [23:0] stored_length
);
	import ltc_pkg::*;

	logic [CACHE_SLOTS-1:0] valid_q;
	logic [15:0] layer_q [CACHE_SLOTS];
	logic [4:0] zoom_q [CACHE_SLOTS];
	logic [23:0] x_q [CACHE_SLOTS];
	logic [23:0] y_q [CACHE_SLOTS];
	logic [23:0] len_q [CACHE_SLOTS];
	logic [31:0] stamp_q [CACHE_SLOTS];
	logic [31:0] ctr_q;

	bk_state_t state_q, state_d;
	item_t item_s1;
	cand_t grp_s2 [NUM_GRPS];
	logic hit_s2, free_s2;
	logic [SLOT_W-1:0] hit_idx_s2, free_idx_s2;
	logic [23:0] hit_len_s2;

	logic rsp_valid_q;
	status_t status_q;
	logic [SLOT_W-1:0] slot_q;
	logic [23:0] len_out_q;

	logic [CACHE_SLOTS-1:0] active, match;
	logic hit_c, free_c;
	logic [SLOT_W-1:0] hit_idx_c, free_idx_c, victim;
	cand_t grp_c [NUM_GRPS];
	cand_t best;
	logic out_free, load;

	always_comb begin
		for (int i = 0; i < CACHE_SLOTS; i++) begin
			active[i] = (CNT_W'(i) < n_active);
			match[i] = active[i] && valid_q[i] && layer_q[i] == item_s1.layer_id &&
				zoom_q[i] == item_s1.zoom && x_q[i] == item_s1.tile_x &&
				y_q[i] == item_s1.tile_y;
		end
		hit_c = 1'b0;
		hit_idx_c = '0;
		free_c = 1'b0;
		free_idx_c = '0;
		for (int i = CACHE_SLOTS - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit_c = 1'b1;
				hit_idx_c = SLOT_W'(i);
			end
			if (active[i] && !valid_q[i]) begin
				free_c = 1'b1;
				free_idx_c = SLOT_W'(i);
			end
		end
		// first level of the oldest search, one winner per group
		for (int g = 0; g < NUM_GRPS; g++) begin
			cand_t c;
			grp_c[g] = '0;
			for (int k = 0; k < GRP_SIZE; k++) begin
				if (g * GRP_SIZE + k < CACHE_SLOTS) begin
					c.found = active[g * GRP_SIZE + k] && stamp_q[g * GRP_SIZE + k] != STAMP_MAX;
					c.stamp = stamp_q[g * GRP_SIZE + k];
					c.idx = SLOT_W'(g * GRP_SIZE + k);
					grp_c[g] = cand_pick(grp_c[g], c);
				end
			end
		end
	end

	always_comb begin
		best = '0;
		for (int g = 0; g < NUM_GRPS; g++)
			best = cand_pick(best, grp_s2[g]);
		if (free_s2)
			victim = free_idx_s2;
		else if (best.found)
			victim = best.idx;
		else
			victim = '0;
	end

	assign out_free = !rsp_valid_q || rsp_ready;

	always_comb begin
		state_d = state_q;
		item_pop = 1'b0;
		load = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (item_valid) begin
					item_pop = 1'b1;
					state_d = BK_EVAL;
				end
			end
			BK_EVAL: state_d = BK_DONE;
			BK_DONE: begin
				if (out_free) begin
					load = 1'b1;
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= BK_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (item_pop)
			item_s1 <= item;
		if (state_q == BK_EVAL) begin
			grp_s2 <= grp_c;
			hit_s2 <= hit_c;
			hit_idx_s2 <= hit_idx_c;
			free_s2 <= free_c;
			free_idx_s2 <= free_idx_c;
			hit_len_s2 <= len_q[hit_idx_c];
		end
	end

	// tag store write-back
	always_ff @(posedge clk) begin
		if (load && item_s1.op == OP_INSERT) begin
			layer_q[victim] <= item_s1.layer_id;
			zoom_q[victim] <= item_s1.zoom;
			x_q[victim] <= item_s1.tile_x;
			y_q[victim] <= item_s1.tile_y;
			len_q[victim] <= item_s1.tile_length;
			stamp_q[victim] <= ctr_q + 32'd1;
		end else if (load && item_s1.op == OP_LOOKUP && hit_s2) begin
			stamp_q[hit_idx_s2] <= ctr_q + 32'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			ctr_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (load && item_s1.op == OP_INSERT)
				valid_q[victim] <= 1'b1;
			if (load && (item_s1.op == OP_INSERT || (item_s1.op == OP_LOOKUP && hit_s2)))
				ctr_q <= ctr_q + 32'd1;
			if (load)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			case (item_s1.op)
				OP_INSERT: begin
					status_q <= ST_INSERTED;
					slot_q <= victim;
					len_out_q <= '0;
				end
				OP_LOOKUP: begin
					status_q <= hit_s2 ? ST_HIT : ST_MISS;
					slot_q <= hit_s2 ? hit_idx_s2 : '0;
					len_out_q <= hit_s2 ? hit_len_s2 : '0;
				end
				default: begin
					status_q <= ST_IGNORED;
					slot_q <= '0;
					len_out_q <= '0;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign status = status_q;
	assign slot = 4'(slot_q);
	assign stored_length = len_out_q;
endmodule
`default_nettype wire

[rtl/lru_tile_tag_cache.sv]
// top level of the tile tag cache: config register, front and back ends
//
// channel | signals                                   | dir
// req     | req_valid/req_ready, kind..tile_length    | in
// rsp     | rsp_valid/rsp_ready, status, slot, length | out
// cfg     | psel/penable/pwrite/paddr/pwdata/prdata   | in/out
//
// in the back end each request passes a fetch from the queue, then a compare
// and group-minimum stage, then the final minimum and write-back.
// the front queue holds two requests, so it fills while the back end works.
// reset clears valid bits, access counter and queue; stamps are not cleared.
// a stalled response holds the back end in its write-back step.
`default_nettype none
module lru_tile_tag_cache (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_ready,
	input wire logic kind,
	input wire logic [15:0] layer_id,
	input wire logic [4:0] zoom,
	input wire logic [23:0] tile_x,
	input wire logic [23:0] tile_y,
	input wire logic [23:0] tile_length,
	output logic rsp_valid,
	input wire logic rsp_ready,
	output logic [1:0] status,
	output logic [3:0] slot,
	output logic [23:0] stored_length,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [2:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import ltc_pkg::*;

	logic [4:0] in_use_q;
	logic [CNT_W-1:0] n_active;
	logic item_valid, item_pop;
	item_t item;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {27'd0, in_use_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			in_use_q <= CFG_RESET;
		else if (psel && penable && pwrite && paddr[2] == 1'b0)
			in_use_q <= pwdata[4:0];
	end

	// zero acts as one, large values clip at the built depth
	always_comb begin
		if (in_use_q == 5'd0)
			n_active = CNT_W'(1);
		else if (32'(in_use_q) > CACHE_SLOTS)
			n_active = CNT_W'(CACHE_SLOTS);
		else
			n_active = CNT_W'(in_use_q);
	end

	ltc_front u_front (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready),
		.kind(kind), .layer_id(layer_id), .zoom(zoom),
		.tile_x(tile_x), .tile_y(tile_y), .tile_length(tile_length),
		.item_valid(item_valid), .item(item), .item_pop(item_pop)
	);

	ltc_back u_back (
		.clk(clk), .arst_n(arst_n), .n_active(n_active),
		.item_valid(item_valid), .item(item), .item_pop(item_pop),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
		.status(status), .slot(slot), .stored_length(stored_length)
	);
endmodule
`default_nettype wire

[rtl/ltc_checker.sv]
// port checker for the tile tag cache and its bind
`default_nettype none
`include "assert_macros.svh"
module ltc_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire logic [1:0] status,
	input wire logic [3:0] slot,
	input wire logic [23:0] stored_length
);
	import ltc_pkg::*;

	`CHK_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(status), "response dropped")
	`CHK_IMPL(a_miss_zero, clk, arst_n, rsp_valid && (status == ST_MISS || status == ST_IGNORED), slot == 4'd0 && stored_length == 24'd0, "miss carries data")
	`CHK_IMPL(a_ins_len, clk, arst_n, rsp_valid && status == ST_INSERTED, stored_length == 24'd0, "insert carries a length")
endmodule

bind lru_tile_tag_cache ltc_checker u_ltc_checker (
	.clk(clk), .arst_n(arst_n), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
	.status(status), .slot(slot), .stored_length(stored_length)
);
`default_nettype wire
